FILE: hw/rtl/i2p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_pkg: shared types and constants of the infix to postfix converter
// Transfer payloads, character codes, symbol classes and control states.
// ----------------------------------------------------------------------------
package i2p_pkg;

    localparam int unsigned SYM_W = 8;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [SYM_W-1:0] CH_MUL    = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV    = 8'h2F;
    localparam logic [SYM_W-1:0] CH_ADD    = 8'h2B;
    localparam logic [SYM_W-1:0] CH_SUB    = 8'h2D;
    localparam logic [SYM_W-1:0] CH_NUL    = 8'h00;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNMATCHED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic             op;
        logic [SYM_W-1:0] symbol;
    } i2p_in_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             last;
        logic [1:0]       error;
    } i2p_out_t;

    typedef struct packed {
        logic push;
        logic pop;
    } i2p_ctl_t;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_FLUSH,
        CLS_CHAR,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_MUL,
        CLS_ADD
    } i2p_cls_t;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } i2p_state_t;

    function automatic logic is_mul(input logic [SYM_W-1:0] c);
        return (c == CH_MUL) || (c == CH_DIV);
    endfunction

    function automatic logic is_arith(input logic [SYM_W-1:0] c);
        return (c == CH_MUL) || (c == CH_DIV) || (c == CH_ADD) || (c == CH_SUB);
    endfunction

    function automatic i2p_cls_t classify(input logic op, input logic [SYM_W-1:0] c);
        i2p_cls_t cls;
        if (op == OP_END) begin
            cls = CLS_FLUSH;
        end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h30 && c <= 8'h39)) begin
            cls = CLS_CHAR;
        end else if (c == CH_LPAREN) begin
            cls = CLS_OPEN;
        end else if (c == CH_RPAREN) begin
            cls = CLS_CLOSE;
        end else if (is_mul(c)) begin
            cls = CLS_MUL;
        end else if ((c == CH_ADD) || (c == CH_SUB)) begin
            cls = CLS_ADD;
        end else begin
            cls = CLS_NONE;
        end
        return cls;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/i2p_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_cell: one entry of the shifting operator stack
// Takes the upper neighbor on a push and the lower neighbor on a pop.
// ----------------------------------------------------------------------------
module i2p_cell (
    input  wire logic                          aclk,
    input  wire i2p_pkg::i2p_ctl_t             ctl,
    input  wire logic [i2p_pkg::SYM_W-1:0]     up_data,
    input  wire logic [i2p_pkg::SYM_W-1:0]     down_data,
    output      logic [i2p_pkg::SYM_W-1:0]     data
);

    logic [i2p_pkg::SYM_W-1:0] data_reg;
    logic [i2p_pkg::SYM_W-1:0] data_next;

    always_comb begin
        priority if (ctl.push) begin
            data_next = up_data;
        end else if (ctl.pop) begin
            data_next = down_data;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/infix_to_postfix_converter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core: shunting-yard infix to postfix converter
//
// Input channel s_*: one infix character per transfer (op = 0), or an end
// marker (op = 1) that flushes the operator stack and emits NUL.
// Result channel m_*: postfix characters and error results; last marks the
// final result caused by an input transfer.
// Operators live in a row of STACK_DEPTH shifting cells; the top is cell 0.
// An input transfer is taken in the idle state; the work state then runs its
// stack steps (one push, one pop, or one emitted result) in order. A letter or
// digit emits itself, an operator emits its pops and then pushes, a close paren
// emits its pops and then drops the open paren, a flush pops every entry and then
// emits NUL, an ignored character is dropped. The next item is taken once the current one is done.
// Results sit in an output register; while a result is pending and the receiver
// stalls, every stack step waits, and the input channel holds off until the item is done.
// Reset empties the stack and clears the output valid; stack contents and the
// output payload need no reset.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire i2p_pkg::i2p_in_t  s_payload,
    output      logic              m_valid,
    input  wire logic              m_ready,
    output      i2p_pkg::i2p_out_t m_payload
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    i2p_pkg::i2p_state_t        state_reg, state_next;
    i2p_pkg::i2p_cls_t          cls_reg, cls_next;
    logic [i2p_pkg::SYM_W-1:0]  sym_reg, sym_next;
    logic                       phase_reg, phase_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       m_valid_reg, m_valid_next;
    i2p_pkg::i2p_out_t          m_payload_reg, m_payload_next;

    i2p_pkg::i2p_ctl_t          ctl;
    logic                       emit;
    i2p_pkg::i2p_out_t          emit_payload;
    logic                       out_free;
    logic                       has_top, has_second, full;
    logic [i2p_pkg::SYM_W-1:0]  top, second;
    logic [i2p_pkg::SYM_W-1:0]  cell_data [STACK_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [i2p_pkg::SYM_W-1:0] up_d, down_d;
            if (gi == 0) begin : g_first
                assign up_d = sym_reg;
            end else begin : g_mid_up
                assign up_d = cell_data[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_last
                assign down_d = cell_data[gi];
            end else begin : g_mid_down
                assign down_d = cell_data[gi+1];
            end
            i2p_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .up_data   (up_d),
                .down_data (down_d),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    assign top        = cell_data[0];
    assign second     = cell_data[1];
    assign has_top    = (count_reg != '0);
    assign has_second = (count_reg > CW'(1));
    assign full       = (count_reg == FULL);
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cls_next     = cls_reg;
        sym_next     = sym_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        ctl          = '0;
        emit         = 1'b0;
        emit_payload = '0;
        s_ready      = 1'b0;

        unique case (state_reg)
            i2p_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cls_next   = i2p_pkg::classify(s_payload.op, s_payload.symbol);
                    sym_next   = s_payload.symbol;
                    phase_next = 1'b0;
                    if (cls_next != i2p_pkg::CLS_NONE) begin
                        state_next = i2p_pkg::ST_WORK;
                    end
                end
            end
            i2p_pkg::ST_WORK: begin
                if (out_free) begin
                    unique case (cls_reg)
                        i2p_pkg::CLS_FLUSH: begin
                            emit = 1'b1;
                            if (has_top) begin
                                ctl.pop                 = 1'b1;
                                emit_payload.out_symbol = top;
                            end else begin
                                emit_payload.out_symbol = i2p_pkg::CH_NUL;
                                emit_payload.last       = 1'b1;
                                state_next              = i2p_pkg::ST_IDLE;
                            end
                        end
                        i2p_pkg::CLS_CHAR: begin
                            emit                    = 1'b1;
                            emit_payload.out_symbol = sym_reg;
                            emit_payload.last       = 1'b1;
                            state_next              = i2p_pkg::ST_IDLE;
                        end
                        i2p_pkg::CLS_CLOSE: begin
                            priority if (has_top && top != i2p_pkg::CH_LPAREN) begin
                                emit                    = 1'b1;
                                ctl.pop                 = 1'b1;
                                emit_payload.out_symbol = top;
                                emit_payload.last       = has_second &&
                                                          (second == i2p_pkg::CH_LPAREN);
                            end else if (has_top) begin
                                ctl.pop    = 1'b1;
                                state_next = i2p_pkg::ST_IDLE;
                            end else begin
                                emit               = 1'b1;
                                emit_payload.error = i2p_pkg::ERR_UNMATCHED;
                                emit_payload.last  = 1'b1;
                                state_next         = i2p_pkg::ST_IDLE;
                            end
                        end
                        i2p_pkg::CLS_MUL, i2p_pkg::CLS_ADD, i2p_pkg::CLS_OPEN: begin
                            priority if (cls_reg == i2p_pkg::CLS_MUL && !phase_reg &&
                                         has_top && i2p_pkg::is_mul(top)) begin
                                // pop one, then push with room guaranteed
                                emit                    = 1'b1;
                                ctl.pop                 = 1'b1;
                                emit_payload.out_symbol = top;
                                emit_payload.last       = 1'b1;
                                phase_next              = 1'b1;
                            end else if (cls_reg == i2p_pkg::CLS_ADD && has_top &&
                                         i2p_pkg::is_arith(top)) begin
                                emit                    = 1'b1;
                                ctl.pop                 = 1'b1;
                                emit_payload.out_symbol = top;
                                emit_payload.last       = !(has_second &&
                                                            i2p_pkg::is_arith(second));
                            end else if (full) begin
                                emit               = 1'b1;
                                emit_payload.error = i2p_pkg::ERR_OVERFLOW;
                                emit_payload.last  = 1'b1;
                                state_next         = i2p_pkg::ST_IDLE;
                            end else begin
                                ctl.push   = 1'b1;
                                state_next = i2p_pkg::ST_IDLE;
                            end
                        end
                        default: begin
                            state_next = i2p_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = i2p_pkg::ST_IDLE;
            end
        endcase

        priority if (ctl.push) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end

        priority if (emit) begin
            m_valid_next   = 1'b1;
            m_payload_next = emit_payload;
        end else if (m_ready) begin
            m_valid_next   = 1'b0;
            m_payload_next = m_payload_reg;
        end else begin
            m_valid_next   = m_valid_reg;
            m_payload_next = m_payload_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= i2p_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg       <= cls_next;
        sym_reg       <= sym_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |-> (count_reg != FULL))
        else $error("push onto a full stack");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |-> (count_reg != '0))
        else $error("pop from an empty stack");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result overwrites a pending transfer");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("stack count out of range");

endmodule
`default_nettype wire

FILE: tb/infix_to_postfix_converter_core_tb.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core_tb: self-checking bench for the converter
// Feeds infix characters and end markers through the input channel and
// checks every postfix result against an in-bench operator stack model.
// Covers operands, precedence, parens, ignored characters, unmatched close
// parens, stack overflow, long receiver stalls and random expressions.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core_tb;

    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 200;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    i2p_pkg::i2p_in_t  s_payload;
    logic              m_valid;
    logic              m_ready;
    i2p_pkg::i2p_out_t m_payload;

    logic [i2p_pkg::SYM_W-1:0] op_stack [STACK_DEPTH];
    int                        op_depth;
    i2p_pkg::i2p_out_t         step_results [$];
    i2p_pkg::i2p_out_t         postfix_expected [$];
    logic [i2p_pkg::SYM_W-1:0] expr_chars [$];
    i2p_pkg::i2p_out_t         oldest;

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned transfers_sent;
    int unsigned effective_sent;
    int unsigned results_checked;
    int unsigned overflow_count;
    int unsigned unmatched_count;
    int          burst_left;
    bit          tx_gaps_on;
    rx_mode_t    rx_mode;
    int          stall_request;
    int          stall_left;
    int          rx_phase;

    always #1 aclk = ~aclk;

    infix_to_postfix_converter_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload)
    );

    // ------------------------------------------------------------------------
    // Operator stack model
    // ------------------------------------------------------------------------
    function automatic void emit_symbol(input logic [i2p_pkg::SYM_W-1:0] sym,
                                        input logic [1:0] err);
        i2p_pkg::i2p_out_t r;
        r.out_symbol = sym;
        r.last = 1'b0;
        r.error = err;
        step_results.push_back(r);
        if (err == i2p_pkg::ERR_OVERFLOW) begin
            overflow_count++;
        end else if (err == i2p_pkg::ERR_UNMATCHED) begin
            unmatched_count++;
        end
    endfunction

    function automatic logic [i2p_pkg::SYM_W-1:0] top_operator();
        return op_stack[op_depth-1];
    endfunction

    function automatic void pop_operator();
        op_depth--;
        emit_symbol(op_stack[op_depth], i2p_pkg::ERR_NONE);
    endfunction

    function automatic void push_operator(input logic [i2p_pkg::SYM_W-1:0] c);
        if (op_depth >= STACK_DEPTH) begin
            emit_symbol(i2p_pkg::CH_NUL, i2p_pkg::ERR_OVERFLOW);
        end else begin
            op_stack[op_depth] = c;
            op_depth++;
        end
    endfunction

    function automatic bit is_operand(input logic [i2p_pkg::SYM_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic bit is_arith_sym(input logic [i2p_pkg::SYM_W-1:0] c);
        return c == i2p_pkg::CH_MUL || c == i2p_pkg::CH_DIV ||
               c == i2p_pkg::CH_ADD || c == i2p_pkg::CH_SUB;
    endfunction

    function automatic void predict_postfix(input i2p_pkg::i2p_in_t item);
        logic [i2p_pkg::SYM_W-1:0] c;
        logic [i2p_pkg::SYM_W-1:0] t;
        i2p_pkg::i2p_out_t         r;
        int                        n;
        c = item.symbol;
        step_results.delete();
        if (item.op == i2p_pkg::OP_END) begin
            while (op_depth > 0) pop_operator();
            emit_symbol(i2p_pkg::CH_NUL, i2p_pkg::ERR_NONE);
        end else if (is_operand(c)) begin
            emit_symbol(c, i2p_pkg::ERR_NONE);
        end else if (c == i2p_pkg::CH_LPAREN) begin
            push_operator(c);
        end else if (c == i2p_pkg::CH_RPAREN) begin
            while (op_depth > 0 && top_operator() != i2p_pkg::CH_LPAREN) pop_operator();
            if (op_depth > 0) begin
                op_depth--;
            end else begin
                emit_symbol(i2p_pkg::CH_NUL, i2p_pkg::ERR_UNMATCHED);
            end
        end else if (c == i2p_pkg::CH_MUL || c == i2p_pkg::CH_DIV) begin
            if (op_depth > 0) begin
                t = top_operator();
                if (t == i2p_pkg::CH_MUL || t == i2p_pkg::CH_DIV) pop_operator();
            end
            push_operator(c);
        end else if (c == i2p_pkg::CH_ADD || c == i2p_pkg::CH_SUB) begin
            while (op_depth > 0) begin
                t = top_operator();
                if (!is_arith_sym(t)) break;
                pop_operator();
            end
            push_operator(c);
        end
        n = step_results.size();
        for (int i = 0; i < n; i++) begin
            r = step_results[i];
            r.last = (i == n - 1);
            postfix_expected.push_back(r);
        end
        if (item.op == i2p_pkg::OP_END || is_operand(c) || c == i2p_pkg::CH_LPAREN ||
            c == i2p_pkg::CH_RPAREN || is_arith_sym(c)) begin
            effective_sent++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [i2p_pkg::SYM_W-1:0] sym);
        i2p_pkg::i2p_in_t item;
        int               gap;
        item.op = op;
        item.symbol = sym;
        if (tx_gaps_on && burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        predict_postfix(item);
        transfers_sent++;
    endtask

    task automatic send_chars();
        foreach (expr_chars[k]) send_item(i2p_pkg::OP_CHAR, expr_chars[k]);
        expr_chars.delete();
    endtask

    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++) send_item(i2p_pkg::OP_CHAR, text[k]);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (postfix_expected.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [i2p_pkg::SYM_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return i2p_pkg::CH_MUL;
            1: return i2p_pkg::CH_DIV;
            2: return i2p_pkg::CH_ADD;
            default: return i2p_pkg::CH_SUB;
        endcase
    endfunction

    function automatic logic [i2p_pkg::SYM_W-1:0] pick_operand();
        case ($urandom_range(0, 2))
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            default: return 8'h30 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic void build_expr(input int level);
        int terms;
        terms = $urandom_range(1, 3);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) expr_chars.push_back(pick_operator());
            if (level < 3 && $urandom_range(0, 3) == 0) begin
                expr_chars.push_back(i2p_pkg::CH_LPAREN);
                build_expr(level + 1);
                expr_chars.push_back(i2p_pkg::CH_RPAREN);
            end else begin
                expr_chars.push_back(pick_operand());
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random or patterned stalls, plus long hold-offs on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 99) < 65);
                default: begin
                    rx_phase = (rx_phase + 1) % 5;
                    m_ready <= (rx_phase != 0 && rx_phase != 3);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 results_checked, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (postfix_expected.size() == 0) begin
                report_mismatch("unexpected transfer, out_symbol",
                                32'(m_payload.out_symbol), 0);
            end else begin
                oldest = postfix_expected.pop_front();
                if (m_payload.out_symbol !== oldest.out_symbol) begin
                    report_mismatch("out_symbol", 32'(m_payload.out_symbol),
                                    32'(oldest.out_symbol));
                end
                if (m_payload.last !== oldest.last) begin
                    report_mismatch("last", 32'(m_payload.last), 32'(oldest.last));
                end
                if (m_payload.error !== oldest.error) begin
                    report_mismatch("error", 32'(m_payload.error), 32'(oldest.error));
                end
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, postfix_expected.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_operands_and_ignored();
        send_text("azAZ09");
        send_item(i2p_pkg::OP_CHAR, 8'h00);
        send_item(i2p_pkg::OP_CHAR, 8'hFF);
        send_item(i2p_pkg::OP_CHAR, 8'h40);
        send_item(i2p_pkg::OP_CHAR, 8'h5B);
        send_item(i2p_pkg::OP_CHAR, 8'h7B);
        send_item(i2p_pkg::OP_END, 8'hFF);
        wait_drain();
    endtask

    task automatic test_precedence();
        send_text("a+b*c-(d/e)*f");
        send_item(i2p_pkg::OP_END, 8'h00);
        send_text("a*b/c-d+e");
        send_item(i2p_pkg::OP_END, 8'hA5);
        wait_drain();
    endtask

    task automatic test_unmatched_close();
        send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_RPAREN);
        send_text("a+b)(c))");
        send_item(i2p_pkg::OP_END, 8'h5A);
        wait_drain();
    endtask

    task automatic test_leftover_open();
        send_text("((a+b");
        send_item(i2p_pkg::OP_END, 8'h00);
        wait_drain();
    endtask

    task automatic test_overflow();
        repeat (STACK_DEPTH) send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_LPAREN);
        send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_LPAREN);
        send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_ADD);
        send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_MUL);
        send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_RPAREN);
        send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_MUL);
        send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_DIV);
        send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_SUB);
        send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_LPAREN);
        send_item(i2p_pkg::OP_END, 8'h00);
        wait_drain();
    endtask

    task automatic test_backpressure();
        rx_mode = RX_ALWAYS;
        tx_gaps_on = 1'b0;
        stall_request = 300;
        repeat (12) begin
            build_expr(0);
            send_chars();
        end
        send_item(i2p_pkg::OP_END, 8'h00);
        // hold the sender until the stalled results have drained
        wait_drain();
    endtask

    task automatic test_random_expressions();
        int unsigned target;
        int          kind;
        int          n;
        target = effective_sent + RANDOM_ITEMS;
        while (effective_sent < target) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) stall_request = $urandom_range(20, 120);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                build_expr(0);
                if ($urandom_range(0, 9) == 0) begin
                    expr_chars.insert($urandom_range(0, expr_chars.size()),
                                      8'($urandom_range(0, 255)));
                end
                send_chars();
                send_item(i2p_pkg::OP_END, 8'($urandom_range(0, 255)));
            end else if (kind < 80) begin
                n = $urandom_range(26, 36);
                repeat (n) expr_chars.push_back(i2p_pkg::CH_LPAREN);
                build_expr(2);
                repeat (n) expr_chars.push_back(i2p_pkg::CH_RPAREN);
                send_chars();
                send_item(i2p_pkg::OP_END, 8'($urandom_range(0, 255)));
            end else if (kind < 95) begin
                repeat ($urandom_range(3, 12)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(i2p_pkg::OP_END, 8'($urandom_range(0, 255)));
                    end else if ($urandom_range(0, 1) == 0) begin
                        send_item(i2p_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
                    end else begin
                        case ($urandom_range(0, 3))
                            0: send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_LPAREN);
                            1: send_item(i2p_pkg::OP_CHAR, i2p_pkg::CH_RPAREN);
                            2: send_item(i2p_pkg::OP_CHAR, pick_operator());
                            default: send_item(i2p_pkg::OP_CHAR, pick_operand());
                        endcase
                    end
                end
            end else begin
                // truncated expression, left on the stack for the next one
                build_expr(0);
                n = $urandom_range(1, expr_chars.size());
                while (expr_chars.size() > n) void'(expr_chars.pop_back());
                send_chars();
            end
        end
        send_item(i2p_pkg::OP_END, 8'h00);
        wait_drain();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_payload <= '0;
        m_ready <= 1'b0;
        op_depth = 0;
        cycle_count = 0;
        mismatches = 0;
        transfers_sent = 0;
        effective_sent = 0;
        results_checked = 0;
        overflow_count = 0;
        unmatched_count = 0;
        burst_left = 0;
        tx_gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
        stall_request = 0;
        stall_left = 0;
        rx_phase = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_operands_and_ignored();
        rx_mode = RX_PATTERN;
        test_precedence();
        rx_mode = RX_ALWAYS;
        test_unmatched_close();
        rx_mode = RX_RANDOM;
        test_leftover_open();
        test_overflow();
        test_backpressure();
        test_random_expressions();

        repeat (60) @(posedge aclk);
        $display("summary: %0d input transfers, %0d results checked in %0d cycles",
                 transfers_sent, results_checked, cycle_count);
        $display("summary: %0d overflow and %0d unmatched-paren results seen",
                 overflow_count, unmatched_count);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
